// ===== rtl/sit_pkg.sv =====
// types and constants shared by the interval table modules
// no dependencies
package sit_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_FIND    = 2'd2,
    CMD_OVERLAP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_ORDER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SCAN,
    EX_SHIFT,
    EX_WRITE,
    EX_DONE
  } ex_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [15:0] room_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] hit_end;
    logic [15:0] hit_room;
    logic        overlaps;
    logic [6:0]  entry_total;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic        reject;
    logic [1:0]  rej_status;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [15:0] room_id;
  } job_t;

endpackage

// ===== rtl/sit_front.sv =====
// front end: takes items, checks interval order, queues jobs
// depends on sit_pkg
module sit_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sit_pkg::in_item_t in_i,
  input  logic             push_i,
  output logic             full_o,
  output sit_pkg::job_t    job_o,
  output logic             job_valid_o,
  input  logic             job_take_i
);

  localparam int unsigned PtrW = $clog2(sit_pkg::QDepth);

  sit_pkg::job_t    q_mem [sit_pkg::QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  sit_pkg::job_t    job_in;
  logic             do_push, do_pop;

  always_comb begin
    job_in.cmd        = sit_pkg::cmd_e'(in_i.command);
    job_in.start_time = in_i.start_time;
    job_in.end_time   = in_i.end_time;
    job_in.room_id    = in_i.room_id;
    job_in.reject     = (in_i.command == sit_pkg::CMD_INSERT) &&
                        (in_i.end_time < in_i.start_time);
    job_in.rej_status = sit_pkg::ST_BAD_ORDER;
  end

  assign full_o      = (cnt_q == (PtrW+1)'(sit_pkg::QDepth));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = job_take_i && job_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/sit_back.sv =====
// back end: walks the sorted table one memory access per cycle
// depends on sit_pkg
module sit_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sit_pkg::job_t     job_i,
  input  logic              job_valid_i,
  output logic              job_take_o,
  output sit_pkg::out_item_t res_o,
  output logic              res_valid_o,
  input  logic              res_take_i
);

  localparam int unsigned IdxW = sit_pkg::IdxW;
  localparam int unsigned CntW = sit_pkg::CntW;

  // one row holds start, end, room
  logic [47:0] mem [sit_pkg::Capacity];
  logic [47:0] rd_data_q;

  sit_pkg::ex_state_e state_q, state_d;
  sit_pkg::job_t      job_q, job_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;    // current read address
  logic [CntW-1:0]    pos_q, pos_d;    // found position
  logic               rd_pend_q, rd_pend_d;
  logic               found_q, found_d;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic [47:0]        wr_data;
  sit_pkg::out_item_t res_q, res_d;
  logic               res_valid_q, res_valid_d;
  logic [15:0]        m_start, m_end, m_room;
  logic [CntW-1:0]    last_idx;

  assign m_start  = rd_data_q[47:32];
  assign m_end    = rd_data_q[31:16];
  assign m_room   = rd_data_q[15:0];
  assign last_idx = idx_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    rd_pend_d   = 1'b0;
    found_d     = found_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[IdxW-1:0];
    wr_data     = rd_data_q;
    job_take_o  = 1'b0;

    if (res_valid_q && res_take_i) res_valid_d = 1'b0;

    unique case (state_q)
      sit_pkg::EX_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          job_d      = job_i;
          idx_d      = '0;
          found_d    = 1'b0;
          state_d    = sit_pkg::EX_SCAN;
        end
      end
      sit_pkg::EX_SCAN: begin
        // examine the row read last cycle, then issue the next read
        if (job_q.reject) begin
          state_d = sit_pkg::EX_DONE;
        end else if (job_q.cmd == sit_pkg::CMD_INSERT &&
                     count_q == CntW'(sit_pkg::Capacity)) begin
          job_d.reject     = 1'b1;
          job_d.rej_status = sit_pkg::ST_FULL;
          state_d          = sit_pkg::EX_DONE;
        end else if (rd_pend_q && !found_d) begin
          unique case (job_q.cmd)
            sit_pkg::CMD_INSERT:  found_d = (m_start > job_q.start_time);
            sit_pkg::CMD_OVERLAP: found_d =
              (job_q.start_time > m_start && job_q.start_time < m_end) ||
              (job_q.end_time > m_start && job_q.end_time < m_end);
            default:              found_d = (m_start == job_q.start_time);
          endcase
          if (found_d) pos_d = last_idx;
        end
        if (state_d == sit_pkg::EX_SCAN) begin
          if (found_d || idx_q == count_q) begin
            if (!found_d) pos_d = count_q;
            unique case (job_q.cmd)
              sit_pkg::CMD_INSERT: begin
                // shift down from the tail: read idx-1, write idx
                idx_d   = count_q;
                state_d = sit_pkg::EX_SHIFT;
              end
              sit_pkg::CMD_REMOVE: begin
                idx_d   = pos_d + 1'b1;
                state_d = found_d ? sit_pkg::EX_SHIFT : sit_pkg::EX_DONE;
              end
              default: state_d = sit_pkg::EX_DONE;
            endcase
            // a find keeps the hit in the job until the result is built
            if (job_q.cmd == sit_pkg::CMD_FIND && found_d) begin
              job_d.end_time = m_end;
              job_d.room_id  = m_room;
            end
          end else begin
            rd_en     = 1'b1;
            rd_pend_d = 1'b1;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      sit_pkg::EX_SHIFT: begin
        if (job_q.cmd == sit_pkg::CMD_INSERT) begin
          if (rd_pend_q) begin
            wr_en   = 1'b1;
            wr_addr = idx_q[IdxW-1:0];
            idx_d   = last_idx;
          end else if (idx_q == pos_q) begin
            state_d = sit_pkg::EX_WRITE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = last_idx[IdxW-1:0];
            rd_pend_d = 1'b1;
          end
        end else begin
          // remove: read idx, write idx-1
          if (rd_pend_q) begin
            wr_en   = 1'b1;
            wr_addr = last_idx[IdxW-1:0];
            idx_d   = idx_q + 1'b1;
          end else if (idx_q >= count_q) begin
            count_d = count_q - 1'b1;
            state_d = sit_pkg::EX_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_pend_d = 1'b1;
          end
        end
      end
      sit_pkg::EX_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[IdxW-1:0];
        wr_data = {job_q.start_time, job_q.end_time, job_q.room_id};
        count_d = count_q + 1'b1;
        state_d = sit_pkg::EX_DONE;
      end
      sit_pkg::EX_DONE: begin
        if (!res_valid_q || res_take_i) begin
          res_valid_d       = 1'b1;
          res_d.status      = job_q.reject ? job_q.rej_status :
                              (job_q.cmd == sit_pkg::CMD_FIND && !found_q) ?
                              sit_pkg::ST_NOT_FOUND : sit_pkg::ST_OK;
          if (job_q.cmd == sit_pkg::CMD_FIND && found_q && !job_q.reject) begin
            res_d.hit_end  = job_q.end_time;
            res_d.hit_room = job_q.room_id;
          end else begin
            res_d.hit_end  = '0;
            res_d.hit_room = '0;
          end
          res_d.overlaps    = (job_q.cmd == sit_pkg::CMD_OVERLAP) && found_q;
          res_d.entry_total = 7'(count_q);
          state_d           = sit_pkg::EX_IDLE;
        end
      end
      default: state_d = sit_pkg::EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sit_pkg::EX_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// ===== rtl/sorted_interval_table.sv =====
// sorted interval table: up to 64 intervals (start, end, room) kept in
// ascending start order in one single-port-style memory. insert scans to its
// slot then moves each later entry down one row (read then write per row);
// remove scans to the match and pulls the tail up the same way; find and
// overlap scan at one row per cycle and stop early on a hit. the memory port
// sets the pace. a two-deep queue behind the input lets new items in while
// one is worked on, and a result register lets a finished result wait for
// pop. no clearing pass is needed after reset.
// depends on sit_pkg, sit_front, sit_back
module sorted_interval_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sit_pkg::in_item_t  in_i,
  input  logic               push,
  output logic               full,
  output sit_pkg::out_item_t out_o,
  output logic               empty,
  input  logic               pop
);

  sit_pkg::job_t job;
  logic          job_valid, job_take;
  logic          res_valid;

  // front: accepts items and flags insert with end before start
  sit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_i      (push),
    .full_o      (full),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_take_i  (job_take)
  );

  // back: table walk, shifting and result register
  sit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .res_o       (out_o),
    .res_valid_o (res_valid),
    .res_take_i  (pop)
  );

  assign empty = !res_valid;

endmodule

// ===== rtl/sit_checker.sv =====
// port-level checks for the interval table, bound to the top level
// depends on sit_pkg
module sit_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input sit_pkg::out_item_t out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o)) else $error("result dropped");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_o.entry_total <= 7'(sit_pkg::Capacity)) else $error("total range");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.status != sit_pkg::ST_OK |-> out_o.overlaps == 1'b0 &&
    out_o.hit_end == '0 && out_o.hit_room == '0) else $error("stale fields");

  a_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.overlaps |-> out_o.hit_end == '0 && out_o.hit_room == '0)
    else $error("overlap with hit");

endmodule

bind sorted_interval_table sit_checker u_sit_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

// ===== tb/sv/sorted_interval_table_test.sv =====
// self-checking testbench for sorted_interval_table: drives commands through the
// push/full port, checks every popped result against a behavioral table model
// depends on sit_pkg and the sorted_interval_table rtl
`timescale 1ns / 1ps

module sorted_interval_table_test;

  // behavioral copy of the table plus the queue of predicted results
  class interval_scoreboard;
    logic [15:0]        starts[$];
    logic [15:0]        ends[$];
    logic [15:0]        rooms[$];
    sit_pkg::out_item_t pending[$];
    int                 mismatches;
    int                 checked;
    int                 hist_status[4];
    int                 hist_cmd[4];
    int                 peak;

    function void note_command(sit_pkg::in_item_t it);
      sit_pkg::out_item_t r;
      int pos;
      r = '0;
      r.status = sit_pkg::ST_OK;
      hist_cmd[it.command]++;
      case (sit_pkg::cmd_e'(it.command))
        sit_pkg::CMD_INSERT: begin
          if (it.end_time < it.start_time) begin
            r.status = sit_pkg::ST_BAD_ORDER;
          end else if (starts.size() >= sit_pkg::Capacity) begin
            r.status = sit_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < starts.size() && starts[pos] <= it.start_time) pos++;
            starts.insert(pos, it.start_time);
            ends.insert(pos, it.end_time);
            rooms.insert(pos, it.room_id);
          end
        end
        sit_pkg::CMD_REMOVE: begin
          pos = find_key(it.start_time);
          if (pos >= 0) begin
            starts.delete(pos);
            ends.delete(pos);
            rooms.delete(pos);
          end
        end
        sit_pkg::CMD_FIND: begin
          pos = find_key(it.start_time);
          if (pos >= 0) begin
            r.hit_end  = ends[pos];
            r.hit_room = rooms[pos];
          end else begin
            r.status = sit_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          foreach (starts[i]) begin
            if ((it.start_time > starts[i] && it.start_time < ends[i]) ||
                (it.end_time > starts[i] && it.end_time < ends[i])) begin
              r.overlaps = 1'b1;
            end
          end
        end
      endcase
      r.entry_total = 7'(starts.size());
      if (starts.size() > peak) peak = starts.size();
      hist_status[r.status]++;
      pending.push_back(r);
    endfunction

    function int find_key(logic [15:0] key);
      foreach (starts[i]) if (starts[i] == key) return i;
      return -1;
    endfunction

    task check_result(sit_pkg::out_item_t got);
      sit_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.hit_end !== want.hit_end)
        report_mismatch("hit_end", got.hit_end, want.hit_end);
      if (got.hit_room !== want.hit_room)
        report_mismatch("hit_room", got.hit_room, want.hit_room);
      if (got.overlaps !== want.overlaps)
        report_mismatch("overlaps", got.overlaps, want.overlaps);
      if (got.entry_total !== want.entry_total)
        report_mismatch("entry_total", got.entry_total, want.entry_total);
    endtask

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %0s: got %0h want %0h at result %0d", what, got, want, checked);
      mismatches++;
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  sit_pkg::in_item_t  in_i;
  logic               push;
  logic               full;
  sit_pkg::out_item_t out_o;
  logic               empty;
  logic               pop;

  interval_scoreboard table_sb;
  int  stall_long;      // receiver holds off while this is nonzero
  bit  stim_done;
  logic [15:0] key_pool[$];   // starts that were inserted, for hits

  sorted_interval_table uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .push  (push),
    .full  (full),
    .out_o (out_o),
    .empty (empty),
    .pop   (pop)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // offer one item and hold it until the block takes it
  task automatic send_item(sit_pkg::in_item_t it);
    in_i <= it;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    table_sb.note_command(it);
  endtask

  // drop push for some idle cycles
  task automatic idle_gap(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_all();
    push <= 1'b0;
    while (table_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic sit_pkg::in_item_t make_item(sit_pkg::cmd_e c, logic [15:0] s,
                                                  logic [15:0] e, logic [15:0] r);
    sit_pkg::in_item_t it;
    it.command    = c;
    it.start_time = s;
    it.end_time   = e;
    it.room_id    = r;
    return it;
  endfunction

  // mostly keys from earlier inserts so remove and find hit often
  function automatic logic [15:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic sit_pkg::in_item_t random_item();
    logic [15:0] s, e;
    int c;
    c = $urandom_range(0, 9);
    s = pick_key();
    e = ($urandom_range(0, 9) == 0) ? 16'($urandom) : s + 16'($urandom_range(0, 4096));
    if (e < s && $urandom_range(0, 1)) e = 16'hffff;
    if (c < 4) return make_item(sit_pkg::CMD_INSERT, s, e, 16'($urandom));
    if (c < 6) return make_item(sit_pkg::CMD_REMOVE, s, 16'($urandom), 16'($urandom));
    if (c < 8) return make_item(sit_pkg::CMD_FIND, s, 16'($urandom), 16'($urandom));
    return make_item(sit_pkg::CMD_OVERLAP, s, e, 16'($urandom));
  endfunction

  // receiver: pops on a random pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) table_sb.check_result(out_o);
      if (stall_long > 0) begin
        stall_long <= stall_long - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 7) < (((table_sb.checked / 200) % 2) ? 8 : 5));
      end
    end
  end

  initial begin
    sit_pkg::in_item_t it;
    int burst;
    table_sb = new();
    stall_long = 0;
    stim_done = 0;
    in_i = '0;
    push = 1'b0;
    pop = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table cases, bad order, equal starts, extremes
    send_item(make_item(sit_pkg::CMD_FIND, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_item(sit_pkg::CMD_REMOVE, 16'h1234, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_OVERLAP, 16'h0001, 16'hffff, 16'h0));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0100, 16'h00ff, 16'hffff));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0000, 16'hffff, 16'hffff));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0500, 16'h0600, 16'h0001));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0500, 16'h0700, 16'h0002));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0500, 16'h0500, 16'h0003));
    send_item(make_item(sit_pkg::CMD_INSERT, 16'hffff, 16'hffff, 16'haaaa));
    send_item(make_item(sit_pkg::CMD_FIND, 16'h0500, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_FIND, 16'hffff, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_OVERLAP, 16'h0580, 16'h0580, 16'h0));
    send_item(make_item(sit_pkg::CMD_OVERLAP, 16'hffff, 16'h0000, 16'h0));
    send_item(make_item(sit_pkg::CMD_REMOVE, 16'h0500, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_FIND, 16'h0500, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_REMOVE, 16'hffff, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_REMOVE, 16'h4321, 16'h0, 16'h0));
    send_item(make_item(sit_pkg::CMD_OVERLAP, 16'h5555, 16'haaaa, 16'h5555));
    drain_all();

    // fill to capacity while the receiver holds off, then overflow
    stall_long <= 400;
    for (int i = 0; i < sit_pkg::Capacity + 2; i++) begin
      send_item(make_item(sit_pkg::CMD_INSERT, 16'($urandom_range(0, 40)), 16'hff00,
                          16'(i)));
      key_pool.push_back(table_sb.starts[0]);
    end
    send_item(make_item(sit_pkg::CMD_INSERT, 16'h0900, 16'h0100, 16'h0));
    send_item(make_item(sit_pkg::CMD_OVERLAP, 16'h0020, 16'h0000, 16'h0));
    drain_all();

    // random bursts with gaps, one deep fill phase midway
    for (int n = 0; n < 1450; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++) begin
        it = random_item();
        if (n > 600 && n < 800 && it.command == sit_pkg::CMD_REMOVE)
          it.command = sit_pkg::CMD_INSERT;
        if (it.command == sit_pkg::CMD_INSERT) key_pool.push_back(it.start_time);
        if (key_pool.size() > 80) void'(key_pool.pop_front());
        send_item(it);
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 300));
    end
    push <= 1'b0;
    stim_done = 1;
    drain_all();
    repeat (300) @(posedge clk_i);

    $display("checked %0d results; peak fill %0d of %0d; commands i/r/f/o %0d/%0d/%0d/%0d",
             table_sb.checked, table_sb.peak, sit_pkg::Capacity,
             table_sb.hist_cmd[sit_pkg::CMD_INSERT], table_sb.hist_cmd[sit_pkg::CMD_REMOVE],
             table_sb.hist_cmd[sit_pkg::CMD_FIND], table_sb.hist_cmd[sit_pkg::CMD_OVERLAP]);
    $display("status ok/full/notfound/badorder %0d/%0d/%0d/%0d",
             table_sb.hist_status[sit_pkg::ST_OK], table_sb.hist_status[sit_pkg::ST_FULL],
             table_sb.hist_status[sit_pkg::ST_NOT_FOUND],
             table_sb.hist_status[sit_pkg::ST_BAD_ORDER]);
    if (table_sb.mismatches == 0 && table_sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit: ~1600 items plus stalls, many times over
  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
